/* hdl/sirs_pkg.sv */
// Shared types and constants for the signed integer to radix symbol converter.
// Used by the top level and by its port checker; depends on nothing.
`timescale 1ns / 1ps

package sirs_pkg;

  localparam int unsigned MAX_SYMBOLS  = 32;
  localparam int unsigned ALPHA_SLOTS  = 32;
  localparam int unsigned SLOT_W       = $clog2(ALPHA_SLOTS);
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned SYM_W        = 8;
  localparam int unsigned LEN_W        = 6;
  localparam int unsigned CFG_DATA_W   = 64;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned STEP_BITS    = 8;
  localparam int unsigned DIV_STEPS    = VALUE_W / STEP_BITS;
  localparam int unsigned DIV_CNT_W    = $clog2(DIV_STEPS);
  localparam int unsigned SYMS_PER_REG = CFG_DATA_W / SYM_W;

  localparam logic [SYM_W-1:0] SIGN_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] SIGN_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_NULL   = 8'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LENGTH  = 3'd0,
    CFG_SYM_0   = 3'd1,
    CFG_SYM_8   = 3'd2,
    CFG_SYM_16  = 3'd3,
    CFG_SYM_24  = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_EMIT
  } state_e;

endpackage

/* hdl/signed_int_to_radix_symbols.sv */
// Signed 32-bit integer to radix symbol converter: one shared divide-step unit under a sequencer.
// The first item after reset or any configuration write first waits while the alphabet is checked.
// Each digit takes a full 32-bit pass of the 8-bit-per-cycle divide unit; up to 32 digits.
// Symbols leave one per cycle unless stalled, via the output register, a sign first if negative.
// Input is stalled until the last symbol is loaded into the output register.
// Reset (asynchronous, active low) clears control and alphabet registers; no symbols until set.
`timescale 1ns / 1ps

module signed_int_to_radix_symbols
  import sirs_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [VALUE_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [SYM_W-1:0]         symbol_o,
  output logic                     last_o
);

  localparam logic [SLOT_W-1:0] LAST_ROT = SLOT_W'(ALPHA_SLOTS - 1);

  state_e                 state_q, state_d;
  logic [LEN_W-1:0]       len_q;
  logic [SYM_W-1:0]       alph_q [ALPHA_SLOTS];
  logic [SYM_W-1:0]       rot_q [ALPHA_SLOTS];
  logic [SYM_W-1:0]       rot_d [ALPHA_SLOTS];
  logic [ALPHA_SLOTS-1:0] rmask_q, rmask_d;
  logic [ALPHA_SLOTS-1:0] lane_in;
  logic [SLOT_W-1:0]      chk_cnt_q, chk_cnt_d;
  logic                   chk_done_q, chk_done_d;
  logic                   chk_ok_q, chk_ok_d;
  logic                   neg_q, neg_d;
  logic                   sign_pend_q, sign_pend_d;
  logic [VALUE_W-1:0]     mag_q, mag_d;
  logic [SLOT_W-1:0]      rem_q, rem_d;
  logic [DIV_CNT_W-1:0]   div_cnt_q, div_cnt_d;
  logic [SLOT_W-1:0]      dig_q [ALPHA_SLOTS];
  logic [SLOT_W-1:0]      dig_d [ALPHA_SLOTS];
  logic [LEN_W-1:0]       nd_q, nd_d;
  logic [LEN_W-1:0]       em_q, em_d;
  logic [SLOT_W-1:0]      em_idx;
  logic                   out_valid_q, out_valid_d;
  logic [SYM_W-1:0]       symbol_q, symbol_d;
  logic                   last_q, last_d;
  logic [SLOT_W-1:0]      div_rem;
  logic [STEP_BITS-1:0]   div_quo;
  logic                   len_ok;
  logic                   lanes_ok;
  logic                   dup_hit;
  logic [VALUE_W-1:0]     raw;

  // Divide step: eight restoring steps of a narrow remainder against the radix.
  always_comb begin
    logic [SLOT_W:0]   t;
    logic [SLOT_W-1:0] r;
    r = rem_q;
    div_quo = '0;
    for (int b = 0; b < STEP_BITS; b++) begin
      t = {r, mag_q[VALUE_W-1-b]};
      if (t >= (SLOT_W+1)'(len_q)) begin
        r = SLOT_W'(t - (SLOT_W+1)'(len_q));
        div_quo[STEP_BITS-1-b] = 1'b1;
      end else begin
        r = t[SLOT_W-1:0];
      end
    end
    div_rem = r;
  end

  always_comb begin
    len_ok = (len_q >= LEN_W'(2)) && (len_q <= LEN_W'(MAX_SYMBOLS));
    lanes_ok = 1'b1;
    dup_hit = 1'b0;
    for (int j = 0; j < ALPHA_SLOTS; j++) begin
      lane_in[j] = (LEN_W'(j) < len_q);
      if (lane_in[j] && (alph_q[j] == SYM_NULL || alph_q[j] == SIGN_MINUS ||
                         alph_q[j] == SIGN_PLUS)) begin
        lanes_ok = 1'b0;
      end
      if (lane_in[j] && rmask_q[j] && (alph_q[j] == rot_q[j])) begin
        dup_hit = 1'b1;
      end
    end
  end

  assign raw    = VALUE_W'(value_i);
  assign em_idx = SLOT_W'(em_q - LEN_W'(1));

  always_comb begin
    state_d     = state_q;
    rot_d       = rot_q;
    rmask_d     = rmask_q;
    chk_cnt_d   = chk_cnt_q;
    chk_done_d  = chk_done_q;
    chk_ok_d    = chk_ok_q;
    neg_d       = neg_q;
    sign_pend_d = sign_pend_q;
    mag_d       = mag_q;
    rem_d       = rem_q;
    div_cnt_d   = div_cnt_q;
    dig_d       = dig_q;
    nd_d        = nd_q;
    em_d        = em_q;
    out_valid_d = out_valid_q;
    symbol_d    = symbol_q;
    last_d      = last_q;

    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          neg_d     = raw[VALUE_W-1];
          mag_d     = raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;
          rem_d     = '0;
          div_cnt_d = '0;
          nd_d      = '0;
          if (chk_done_q) begin
            state_d = chk_ok_q ? ST_DIVIDE : ST_IDLE;
          end else begin
            for (int j = 0; j < ALPHA_SLOTS; j++) begin
              rot_d[j]   = alph_q[(j + 1) % ALPHA_SLOTS];
              rmask_d[j] = lane_in[(j + 1) % ALPHA_SLOTS];
            end
            chk_cnt_d = SLOT_W'(1);
            chk_ok_d  = len_ok && lanes_ok;
            state_d   = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        for (int j = 0; j < ALPHA_SLOTS; j++) begin
          rot_d[j]   = rot_q[(j + 1) % ALPHA_SLOTS];
          rmask_d[j] = rmask_q[(j + 1) % ALPHA_SLOTS];
        end
        if (dup_hit) begin
          chk_ok_d = 1'b0;
        end
        chk_cnt_d = chk_cnt_q + SLOT_W'(1);
        if (chk_cnt_q == LAST_ROT) begin
          chk_done_d = 1'b1;
          state_d    = chk_ok_d ? ST_DIVIDE : ST_IDLE;
        end
      end
      ST_DIVIDE: begin
        mag_d     = {mag_q[VALUE_W-STEP_BITS-1:0], div_quo};
        rem_d     = div_rem;
        div_cnt_d = div_cnt_q + DIV_CNT_W'(1);
        if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          dig_d[nd_q[SLOT_W-1:0]] = div_rem;
          nd_d  = nd_q + LEN_W'(1);
          rem_d = '0;
          if (mag_d == '0 || nd_d == LEN_W'(ALPHA_SLOTS)) begin
            em_d        = nd_d;
            sign_pend_d = neg_q;
            state_d     = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          if (sign_pend_q) begin
            symbol_d    = SIGN_MINUS;
            last_d      = 1'b0;
            sign_pend_d = 1'b0;
          end else begin
            symbol_d = alph_q[dig_q[em_idx]];
            last_d   = (em_q == LEN_W'(1));
            em_d     = em_q - LEN_W'(1);
            if (em_q == LEN_W'(1)) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A new alphabet or length must be checked again before the next item.
    if (cfg_we_i) begin
      chk_done_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      chk_done_q  <= 1'b0;
      chk_ok_q    <= 1'b0;
      out_valid_q <= 1'b0;
      for (int j = 0; j < ALPHA_SLOTS; j++) begin
        alph_q[j] <= '0;
      end
    end else begin
      state_q     <= state_d;
      chk_done_q  <= chk_done_d;
      chk_ok_q    <= chk_ok_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LENGTH: begin
            len_q <= cfg_data_i[LEN_W-1:0];
          end
          CFG_SYM_0: begin
            for (int k = 0; k < SYMS_PER_REG; k++) alph_q[k] <= cfg_data_i[SYM_W*k +: SYM_W];
          end
          CFG_SYM_8: begin
            for (int k = 0; k < SYMS_PER_REG; k++) begin
              alph_q[SYMS_PER_REG + k] <= cfg_data_i[SYM_W*k +: SYM_W];
            end
          end
          CFG_SYM_16: begin
            for (int k = 0; k < SYMS_PER_REG; k++) begin
              alph_q[2*SYMS_PER_REG + k] <= cfg_data_i[SYM_W*k +: SYM_W];
            end
          end
          CFG_SYM_24: begin
            for (int k = 0; k < SYMS_PER_REG; k++) begin
              alph_q[3*SYMS_PER_REG + k] <= cfg_data_i[SYM_W*k +: SYM_W];
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rot_q       <= rot_d;
    rmask_q     <= rmask_d;
    chk_cnt_q   <= chk_cnt_d;
    neg_q       <= neg_d;
    sign_pend_q <= sign_pend_d;
    mag_q       <= mag_d;
    rem_q       <= rem_d;
    div_cnt_q   <= div_cnt_d;
    dig_q       <= dig_d;
    nd_q        <= nd_d;
    em_q        <= em_d;
    symbol_q    <= symbol_d;
    last_q      <= last_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign symbol_o    = symbol_q;
  assign last_o      = last_q;

endmodule

/* hdl/sirs_checker.sv */
// Port-level checker for the radix symbol converter, bound to the top level.
// Depends on sirs_pkg and sees only the ports of signed_int_to_radix_symbols.
`timescale 1ns / 1ps

module sirs_checker
  import sirs_pkg::*;
(
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [SYM_W-1:0]          symbol_o,
  input logic                      last_o
);

  // A stalled item stays on the output unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(symbol_o) && $stable(last_o))
    else $error("output item changed while stalled");

  // A minus sign is always followed by at least one digit.
  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && symbol_o == SIGN_MINUS |-> !last_o)
    else $error("minus sign marked as last symbol");

  // Within a run, symbols follow each other without gaps.
  a_run_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o)
    else $error("gap inside a symbol run");

  // The input is open only once the previous run is fully loaded.
  a_idle_run_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !(out_valid_o && !last_o))
    else $error("input accepted while a run is unfinished");

endmodule

bind signed_int_to_radix_symbols sirs_checker u_sirs_checker (.*);
